// ----- rtl/xoshiro_pkg.sv -----
// shared function codes and the controller-to-datapath command word
package xoshiro_pkg;

	// function codes carried by the func field
	localparam logic [2:0] FUNC_RESEED    = 3'd0;
	localparam logic [2:0] FUNC_RAW       = 3'd1;
	localparam logic [2:0] FUNC_FRAC23    = 3'd2;
	localparam logic [2:0] FUNC_FRAC52    = 3'd3;
	localparam logic [2:0] FUNC_RANGED    = 3'd4;
	localparam logic [2:0] FUNC_JUMP      = 3'd5;
	localparam logic [2:0] FUNC_LONG_JUMP = 3'd6;

	typedef struct packed {
		logic       advance;     // step the generator one draw
		logic       load_word;   // register a word result for func raw/frac23/frac52
		logic       cap_range;   // capture bounds and fraction for a ranged draw
		logic       rng_mul_lo;  // range: magnitude times low fraction half
		logic       rng_mul_hi;  // range: magnitude times high fraction half
		logic       rng_quot;    // range: sum partials, split quotient and remainder
		logic       load_int;    // register the ranged integer result
		logic       sm_load;     // seed expander: load seed plus golden constant
		logic       sm_zero;     // seed expander: use a zero seed
		logic       sm_mix30;    // seed expander: xor with shift by 30
		logic       sm_mix27;    // seed expander: xor with shift by 27
		logic       sm_mul;      // seed expander: one step of the split multiply
		logic       sm_mul_c2;   // second multiplier constant
		logic [1:0] mul_step;    // step of the split multiply
		logic       sm_store;    // write one finished state word
		logic [1:0] st_idx;      // which state word
		logic       jacc_clear;  // clear the jump accumulator
		logic       jacc_fold;   // fold the current state into the accumulator
		logic       jacc_copy;   // move the accumulator into the state
	} cmd_t;

endpackage

// ----- rtl/xoshiro_dp.sv -----
// datapath: state words, seed expander, shared 32x32 multiplier, ranged draw arithmetic
module xoshiro_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  xoshiro_pkg::cmd_t   cmd,
	input  logic                cfg_we,
	input  logic [63:0]         cfg_data,
	input  logic [2:0]          func,
	input  logic signed [31:0]  low_bound,
	input  logic signed [31:0]  high_bound,
	output logic [63:0]         word,
	output logic signed [31:0]  int_result
);
	import xoshiro_pkg::*;

	localparam logic [63:0] SM_GOLDEN = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] SM_C1     = 64'hBF58476D1CE4E5B9;
	localparam logic [63:0] SM_C2     = 64'h94D049BB133111EB;

	logic [63:0] st_q [4];
	logic [63:0] jacc_q [4];
	logic [63:0] seed_q;
	logic [63:0] sm_q;
	logic [63:0] mac_q;
	logic [63:0] prod_q;
	logic signed [31:0] a_q;
	logic        neg_q;
	logic [31:0] m_q;
	logic [51:0] frac_q;
	logic [31:0] quot_q;
	logic        rnz_q;
	logic [63:0] word_q;
	logic signed [31:0] int_q;

	logic [63:0] draw_x;
	logic [63:0] adv [4];
	logic [63:0] rot_in;
	logic signed [32:0] diff;
	logic [32:0] diff_mag;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] mul_p;
	logic [63:0] mul_c;
	logic [83:0] total;
	logic signed [33:0] a_x;
	logic signed [33:0] q_x;
	logic signed [33:0] base;
	logic signed [33:0] base_adj;
	logic [63:0] word_d;

	assign draw_x = st_q[0] + st_q[3];

	// one generator step, written out from the update sequence
	assign rot_in = st_q[3] ^ st_q[1];
	assign adv[0] = st_q[0] ^ st_q[3] ^ st_q[1];
	assign adv[1] = st_q[1] ^ st_q[2] ^ st_q[0];
	assign adv[2] = st_q[2] ^ st_q[0] ^ (st_q[1] << 17);
	assign adv[3] = {rot_in[18:0], rot_in[63:19]};

	// exact 33-bit difference of the bounds and its magnitude
	assign diff     = $signed({high_bound[31], high_bound}) - $signed({low_bound[31], low_bound});
	assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);

	always_comb begin
		case (func)
			FUNC_FRAC23: word_d = {41'd0, draw_x[31:9]};
			FUNC_FRAC52: word_d = {12'd0, draw_x[63:12]};
			default:     word_d = draw_x;
		endcase
	end

	// shared multiplier operand selection
	assign mul_c = cmd.sm_mul_c2 ? SM_C2 : SM_C1;
	always_comb begin
		mul_a = m_q;
		mul_b = frac_q[31:0];
		if (cmd.sm_mul) begin
			case (cmd.mul_step)
				2'd0:    begin mul_a = sm_q[31:0];  mul_b = mul_c[31:0];  end
				2'd1:    begin mul_a = sm_q[63:32]; mul_b = mul_c[31:0];  end
				default: begin mul_a = sm_q[31:0];  mul_b = mul_c[63:32]; end
			endcase
		end else if (cmd.rng_mul_lo) begin
			mul_a = m_q;
			mul_b = frac_q[31:0];
		end else if (cmd.rng_mul_hi) begin
			mul_b = {12'd0, frac_q[51:32]};
		end
	end
	assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

	assign total = {20'd0, mac_q} + {prod_q[51:0], 32'd0};

	assign a_x  = $signed({{2{a_q[31]}}, a_q});
	assign q_x  = $signed({2'b00, quot_q});
	assign base = neg_q ? (a_x - q_x) : (a_x + q_x);
	always_comb begin
		base_adj = base;
		if (rnz_q && !neg_q && base < 34'sd0)
			base_adj = base + 34'sd1;
		else if (rnz_q && neg_q && base > 34'sd0)
			base_adj = base - 34'sd1;
	end

	// seed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (cfg_we) begin
			seed_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		// generator state
		if (cmd.sm_store) begin
			st_q[cmd.st_idx] <= sm_q ^ (sm_q >> 31);
		end else if (cmd.advance) begin
			for (int k = 0; k < 4; k++) st_q[k] <= adv[k];
		end else if (cmd.jacc_copy) begin
			for (int k = 0; k < 4; k++) st_q[k] <= jacc_q[k];
		end

		// jump accumulator
		if (cmd.jacc_clear) begin
			for (int k = 0; k < 4; k++) jacc_q[k] <= '0;
		end else if (cmd.jacc_fold) begin
			for (int k = 0; k < 4; k++) jacc_q[k] <= jacc_q[k] ^ st_q[k];
		end

		// seed expander
		if (cmd.sm_load)
			sm_q <= (cmd.sm_zero ? 64'd0 : seed_q) + SM_GOLDEN;
		else if (cmd.sm_mix30)
			sm_q <= sm_q ^ (sm_q >> 30);
		else if (cmd.sm_mix27)
			sm_q <= sm_q ^ (sm_q >> 27);
		else if (cmd.sm_mul && cmd.mul_step == 2'd3)
			sm_q <= mac_q + {prod_q[31:0], 32'd0};

		// multiplier and partial-product accumulator
		prod_q <= mul_p;
		if ((cmd.sm_mul && cmd.mul_step == 2'd1) || cmd.rng_mul_hi)
			mac_q <= prod_q;
		else if (cmd.sm_mul && cmd.mul_step == 2'd2)
			mac_q <= mac_q + {prod_q[31:0], 32'd0};

		// ranged draw operands
		if (cmd.cap_range) begin
			a_q    <= low_bound;
			neg_q  <= diff[32];
			m_q    <= diff_mag[31:0];
			frac_q <= draw_x[63:12];
		end
		if (cmd.rng_quot) begin
			quot_q <= total[83:52];
			rnz_q  <= |total[51:0];
		end

		// result registers
		if (cmd.load_word) begin
			word_q <= word_d;
			int_q  <= '0;
		end else if (cmd.load_int) begin
			word_q <= '0;
			int_q  <= $signed(base_adj[31:0]);
		end
	end

	assign word       = word_q;
	assign int_result = int_q;

endmodule

// ----- rtl/xoshiro_ctrl.sv -----
// controller: input acceptance, seed, range and jump sequencing, result valid
module xoshiro_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        func,
	output logic              out_valid,
	input  logic              out_ready,
	output xoshiro_pkg::cmd_t cmd
);
	import xoshiro_pkg::*;

	localparam logic [255:0] JUMP_POLY = {
		64'h39abdc4529b1661c, 64'ha9582618e03fc9aa,
		64'hd5a61266f0c9392c, 64'h180ec6d33cfd0aba
	};
	localparam logic [255:0] LONG_JUMP_POLY = {
		64'h39109bb02acbe635, 64'h77710069854ee241,
		64'hc5004e441c522fb3, 64'h76e15d3efefdcbbf
	};

	typedef enum logic [12:0] {
		S_IDLE    = 13'b0000000000001,
		S_LOAD    = 13'b0000000000010,
		S_MIX30   = 13'b0000000000100,
		S_MUL1    = 13'b0000000001000,
		S_MIX27   = 13'b0000000010000,
		S_MUL2    = 13'b0000000100000,
		S_STORE   = 13'b0000001000000,
		S_RMUL_LO = 13'b0000010000000,
		S_RMUL_HI = 13'b0000100000000,
		S_RQUOT   = 13'b0001000000000,
		S_ROUT    = 13'b0010000000000,
		S_JUMP    = 13'b0100000000000,
		S_JCOPY   = 13'b1000000000000
	} state_t;

	state_t      state_q, state_d;
	logic [1:0]  step_q, step_d;
	logic [1:0]  idx_q, idx_d;
	logic [7:0]  jcnt_q, jcnt_d;
	logic        long_q, long_d;
	logic        boot_q;
	logic        out_valid_q;
	logic        in_acc;
	logic        poly_bit;

	assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign in_acc   = in_valid && in_ready;
	assign poly_bit = long_q ? LONG_JUMP_POLY[jcnt_q] : JUMP_POLY[jcnt_q];

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		step_d  = step_q;
		idx_d   = idx_q;
		jcnt_d  = jcnt_q;
		long_d  = long_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					case (func)
						FUNC_RESEED: state_d = S_LOAD;
						FUNC_RAW, FUNC_FRAC23, FUNC_FRAC52: begin
							cmd.advance   = 1'b1;
							cmd.load_word = 1'b1;
						end
						FUNC_RANGED: begin
							cmd.advance   = 1'b1;
							cmd.cap_range = 1'b1;
							state_d       = S_RMUL_LO;
						end
						FUNC_JUMP, FUNC_LONG_JUMP: begin
							cmd.jacc_clear = 1'b1;
							jcnt_d         = '0;
							long_d         = (func == FUNC_LONG_JUMP);
							state_d        = S_JUMP;
						end
						default: ;
					endcase
				end
			end
			S_LOAD: begin
				cmd.sm_load = 1'b1;
				cmd.sm_zero = boot_q;
				idx_d       = '0;
				state_d     = S_MIX30;
			end
			S_MIX30: begin
				cmd.sm_mix30 = 1'b1;
				step_d       = '0;
				state_d      = S_MUL1;
			end
			S_MUL1: begin
				cmd.sm_mul   = 1'b1;
				cmd.mul_step = step_q;
				step_d       = step_q + 2'd1;
				if (step_q == 2'd3)
					state_d = S_MIX27;
			end
			S_MIX27: begin
				cmd.sm_mix27 = 1'b1;
				step_d       = '0;
				state_d      = S_MUL2;
			end
			S_MUL2: begin
				cmd.sm_mul    = 1'b1;
				cmd.sm_mul_c2 = 1'b1;
				cmd.mul_step  = step_q;
				step_d        = step_q + 2'd1;
				if (step_q == 2'd3)
					state_d = S_STORE;
			end
			S_STORE: begin
				cmd.sm_store = 1'b1;
				cmd.st_idx   = idx_q;
				idx_d        = idx_q + 2'd1;
				state_d      = (idx_q == 2'd3) ? S_IDLE : S_MIX30;
			end
			S_RMUL_LO: begin
				cmd.rng_mul_lo = 1'b1;
				state_d        = S_RMUL_HI;
			end
			S_RMUL_HI: begin
				cmd.rng_mul_hi = 1'b1;
				state_d        = S_RQUOT;
			end
			S_RQUOT: begin
				cmd.rng_quot = 1'b1;
				state_d      = S_ROUT;
			end
			S_ROUT: begin
				cmd.load_int = 1'b1;
				state_d      = S_IDLE;
			end
			S_JUMP: begin
				cmd.jacc_fold = poly_bit;
				cmd.advance   = 1'b1;
				jcnt_d        = jcnt_q + 8'd1;
				if (jcnt_q == 8'hFF)
					state_d = S_JCOPY;
			end
			S_JCOPY: begin
				cmd.jacc_copy = 1'b1;
				state_d       = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			step_q      <= '0;
			idx_q       <= '0;
			jcnt_q      <= '0;
			long_q      <= 1'b0;
			boot_q      <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			idx_q   <= idx_d;
			jcnt_q  <= jcnt_d;
			long_q  <= long_d;
			if (state_q == S_LOAD)
				boot_q <= 1'b0;
			if (cmd.load_word || cmd.load_int)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTH
	// a ranged result never lands on a word still waiting downstream
	a_rout_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ROUT |-> (!out_valid_q || out_ready))
		else $error("ranged result would overwrite a pending word");

	// a plain draw shows its word on the next cycle
	a_draw_valid: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (func == FUNC_RAW || func == FUNC_FRAC23 || func == FUNC_FRAC52)
		|=> out_valid_q)
		else $error("draw accepted without a result");

	// the jump copy comes only after the last of the 256 fold steps
	a_jump_length: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_JCOPY |-> ($past(state_q) == S_JUMP && $past(jcnt_q) == 8'hFF))
		else $error("jump copy out of sequence");

	// the zero-seed boot pass runs only from the load state
	a_boot_load: assert property (@(posedge clk) disable iff (!arst_n)
		boot_q |-> state_q == S_LOAD)
		else $error("boot seed pass left the load state");
`endif

endmodule

// ----- rtl/xoshiro256plus_generator.sv -----
// top level of the xoshiro256+ generator with seed expansion, fractions, ranged draw and jumps
//
// channel  direction  handshake              word
// in       to block   in_valid / in_ready    func, low_bound, high_bound
// out      from block out_valid / out_ready  word, int_result
// cfg      to block   cfg_valid / cfg_ready  cfg_data (seed_value)
//
// raw, frac23, frac52: word valid the cycle after accept, one item per cycle while out drains
// ranged: two multiplier passes, S_RQUOT and S_ROUT, then the result; no new item until idle
// reseed: per state word mix30, split 64-bit multiply, mix27, second split multiply, store
// jump and long jump: the accept clears the accumulator, then 256 fold steps and the copy
// after reset the block runs the zero-seed expansion with in_ready low
// a word waiting on out with out_ready low holds off new items; cfg_ready is always high
module xoshiro256plus_generator (
	input  logic               clk,
	input  logic               arst_n,
	// item input
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         func,
	input  logic signed [31:0] low_bound,
	input  logic signed [31:0] high_bound,
	// result output
	output logic               out_valid,
	input  logic               out_ready,
	output logic [63:0]        word,
	output logic signed [31:0] int_result,
	// seed register write
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [63:0]        cfg_data
);
	import xoshiro_pkg::*;

	cmd_t cmd;

	// the seed register takes a write on any cycle
	assign cfg_ready = 1'b1;

	// sequencing of accepts, seed expansion, ranged draw and jump folding
	xoshiro_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// state words, multiplier and result registers
	xoshiro_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg_we     (cfg_valid),
		.cfg_data   (cfg_data),
		.func       (func),
		.low_bound  (low_bound),
		.high_bound (high_bound),
		.word       (word),
		.int_result (int_result)
	);

endmodule

// ----- verif/tb.sv -----
// testbench for the xoshiro256+ generator: predicted draws, reseeds and jumps under random flow control
`timescale 1ns / 100ps

module tb;
	import xoshiro_pkg::*;

	// the one code the package leaves out, the block drops it
	localparam logic [2:0] FUNC_UNUSED = 3'd7;

	// fixed step budget after the last result: a long jump runs its fold steps and copy with no word out
	localparam int SETTLE_CYCLES = 300;
	localparam int PHASE_ITEMS   = 270;
	localparam int SEED_PHASES   = 6;

	// one expected result word pair
	typedef struct {
		bit [2:0]  f;
		bit [63:0] w;
		bit [31:0] r;
	} draw_t;

	// receiver stall patterns
	typedef enum int {
		DRAIN_FREE,
		DRAIN_COIN,
		DRAIN_SKIP,
		DRAIN_LONG
	} drain_mode_e;

	// generator model plus the queue of draws still owed by the block
	class draw_scoreboard;
		localparam bit [63:0] GOLDEN = 64'h9E37_79B9_7F4A_7C15;
		localparam bit [63:0] MIX_1  = 64'hBF58_476D_1CE4_E5B9;
		localparam bit [63:0] MIX_2  = 64'h94D0_49BB_1331_11EB;
		localparam bit [255:0] JUMP_POLY = {
			64'h39ab_dc45_29b1_661c, 64'ha958_2618_e03f_c9aa,
			64'hd5a6_1266_f0c9_392c, 64'h180e_c6d3_3cfd_0aba};
		localparam bit [255:0] LONG_JUMP_POLY = {
			64'h3910_9bb0_2acb_e635, 64'h7771_0069_854e_e241,
			64'hc500_4e44_1c52_2fb3, 64'h76e1_5d3e_fefd_cbbf};

		bit [63:0] st [4];
		bit [63:0] seed;
		draw_t     owed_q [$];
		int        errors;
		int        checked;
		int        seed_writes;
		int        func_count [8];

		function new();
			seed = '0;
			errors = 0;
			checked = 0;
			seed_writes = 0;
			foreach (func_count[k]) func_count[k] = 0;
			expand(seed);
		endfunction

		// seed expansion into the four state words: splitmix64 mixing, golden added once, z chained
		function void expand(bit [63:0] s);
			bit [63:0] z;
			z = s + GOLDEN;
			for (int k = 0; k < 4; k++) begin
				z = (z ^ (z >> 30)) * MIX_1;
				z = (z ^ (z >> 27)) * MIX_2;
				st[k] = z ^ (z >> 31);
			end
		endfunction

		// one generator step, returns s0 + s3 taken before the update
		function bit [63:0] step();
			bit [63:0] x;
			bit [63:0] t;
			x = st[0] + st[3];
			t = st[1] << 17;
			st[2] ^= st[0];
			st[3] ^= st[1];
			st[1] ^= st[2];
			st[0] ^= st[3];
			st[2] ^= t;
			st[3] = {st[3][18:0], st[3][63:19]};
			return x;
		endfunction

		// xor together the states picked by the polynomial over 256 steps
		function void jump_ahead(bit [255:0] poly);
			bit [63:0] acc [4];
			foreach (acc[k]) acc[k] = '0;
			for (int j = 0; j < 256; j++) begin
				if (poly[j]) begin
					foreach (acc[k]) acc[k] ^= st[k];
				end
				void'(step());
			end
			foreach (st[k]) st[k] = acc[k];
		endfunction

		// a + (b - a) * frac / 2^52 truncated toward zero, span taken at full width
		function bit [31:0] ranged(int a, int b, bit [51:0] frac);
			longint    sa;
			longint    span;
			longint    q;
			longint    res;
			bit [63:0] mag;
			bit [127:0] wm;
			bit [127:0] wf;
			bit [127:0] prod;
			bit        nz;
			sa = a;
			span = longint'(b) - sa;
			mag = (span < 0) ? -span : span;
			wm = mag;
			wf = frac;
			prod = wm * wf;
			q = longint'(prod[115:52]);
			nz = prod[51:0] != '0;
			if (span >= 0) begin
				res = sa + q;
				if (nz && res < 0) res += 1;
			end else begin
				res = sa - q;
				if (nz && res > 0) res -= 1;
			end
			return res[31:0];
		endfunction

		function void set_seed(bit [63:0] v);
			seed = v;
			seed_writes++;
		endfunction

		// accepted input word: advance the model, queue any result it owes
		function void note_item(bit [2:0] f, int a, int b);
			draw_t     e;
			bit [63:0] x;
			func_count[f]++;
			e.f = f;
			e.w = '0;
			e.r = '0;
			case (f)
			FUNC_RESEED: expand(seed);
			FUNC_RAW: begin
				e.w = step();
				owed_q.push_back(e);
			end
			FUNC_FRAC23: begin
				x = step();
				e.w = {41'b0, x[31:9]};
				owed_q.push_back(e);
			end
			FUNC_FRAC52: begin
				x = step();
				e.w = {12'b0, x[63:12]};
				owed_q.push_back(e);
			end
			FUNC_RANGED: begin
				x = step();
				e.r = ranged(a, b, x[63:12]);
				owed_q.push_back(e);
			end
			FUNC_JUMP:      jump_ahead(JUMP_POLY);
			FUNC_LONG_JUMP: jump_ahead(LONG_JUMP_POLY);
			default: ;
			endcase
		endfunction

		function int owed();
			return owed_q.size();
		endfunction

		task report(string msg);
			$display("mismatch @%0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(logic [63:0] w, logic [31:0] r);
			draw_t e;
			if (owed_q.size() == 0) begin
				report($sformatf("word %h int %h with nothing owed", w, r));
				return;
			end
			e = owed_q.pop_front();
			checked++;
			if (w !== e.w)
				report($sformatf("func %0d word %h, want %h", e.f, w, e.w));
			if (r !== e.r)
				report($sformatf("func %0d int_result %h, want %h", e.f, r, e.r));
		endtask

		task finish_check();
			if (owed_q.size() != 0)
				report($sformatf("%0d results never came", owed_q.size()));
		endtask
	endclass

	logic               clk;
	logic               arst_n     = 1'b0;
	logic               in_valid   = 1'b0;
	logic               in_ready;
	logic [2:0]         func       = '0;
	logic signed [31:0] low_bound  = '0;
	logic signed [31:0] high_bound = '0;
	logic               out_valid;
	logic               out_ready  = 1'b0;
	logic [63:0]        word;
	logic signed [31:0] int_result;
	logic               cfg_valid  = 1'b0;
	logic               cfg_ready;
	logic [63:0]        cfg_data   = '0;

	draw_scoreboard sb = new();

	// words left in the current sender burst
	int burst_left = 0;

	xoshiro256plus_generator i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.low_bound  (low_bound),
		.high_bound (high_bound),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.word       (word),
		.int_result (int_result),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// hard stop well past the slowest legal run
	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	// handshakes seen at the edge: results first so a same-edge input cannot satisfy them
	always @(posedge clk) begin
		if (out_valid && out_ready) sb.check_result(word, int_result);
		if (in_valid && in_ready) sb.note_item(func, low_bound, high_bound);
		if (cfg_valid && cfg_ready) sb.set_seed(cfg_data);
	end

	// receiver back-pressure, in randomly chosen patterns held for random spans
	initial begin : drain_pattern
		drain_mode_e mode;
		int          span;
		int          tick;
		tick = 0;
		forever begin
			mode = drain_mode_e'($urandom_range(0, 3));
			span = $urandom_range(16, 120);
			repeat (span) begin
				@(posedge clk);
				tick++;
				case (mode)
				DRAIN_FREE: out_ready <= 1'b1;
				DRAIN_COIN: out_ready <= 1'($urandom_range(0, 1));
				DRAIN_SKIP: out_ready <= (tick % 5) != 0;
				default:    out_ready <= (tick % 23) >= 15;
				endcase
			end
		end
	end

	// present one input word and hold it until taken; gaps fall between bursts
	task automatic send(logic [2:0] f, int a, int b);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			// now and then a long burst with no gaps at all
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
			                                         : $urandom_range(1, 16);
		end
		burst_left--;
		in_valid   <= 1'b1;
		func       <= f;
		low_bound  <= a;
		high_bound <= b;
		do @(posedge clk); while (!in_ready);
	endtask

	// drop valid and hold off until every owed result has been taken
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.owed() != 0);
	endtask

	// seed writes only once the block has gone quiet, a jump leaves no result to wait on
	task automatic write_seed(logic [63:0] v);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [2:0] pick_func();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)  return FUNC_RESEED;
		if (r < 9)  return FUNC_JUMP;
		if (r < 12) return FUNC_LONG_JUMP;
		if (r < 15) return FUNC_UNUSED;
		if (r < 35) return FUNC_RAW;
		if (r < 50) return FUNC_FRAC23;
		if (r < 65) return FUNC_FRAC52;
		return FUNC_RANGED;
	endfunction

	// bounds weighted toward the corners of the signed range
	function automatic int pick_bound();
		case ($urandom_range(0, 7))
		0:       return 32'h8000_0000;
		1:       return 32'h7FFF_FFFF;
		2:       return $urandom_range(0, 64) - 32;
		3:       return 0;
		default: return $urandom;
		endcase
	endfunction

	initial begin : stimulus
		logic [2:0]  f;
		int          a;
		int          b;
		int          n;
		logic [63:0] s;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_seed('1);

		// directed: draws straight from the zero-seed state after reset
		send(FUNC_RAW, 0, 0);
		send(FUNC_FRAC23, 0, 0);
		send(FUNC_FRAC52, 0, 0);
		// widest range, its inverse, empty and one-wide ranges and a short reversed range
		send(FUNC_RANGED, 32'h8000_0000, 32'h7FFF_FFFF);
		send(FUNC_RANGED, 32'h7FFF_FFFF, 32'h8000_0000);
		send(FUNC_RANGED, 0, 0);
		send(FUNC_RANGED, 32'h8000_0000, 32'h8000_0000);
		send(FUNC_RANGED, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send(FUNC_RANGED, -1, 0);
		send(FUNC_RANGED, 0, 1);
		send(FUNC_RANGED, 5, -5);
		// unused code must leave the state alone, then draws around a reseed, a jump and a long jump
		send(FUNC_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send(FUNC_RAW, 0, 0);
		send(FUNC_RESEED, 0, 0);
		send(FUNC_RAW, 0, 0);
		send(FUNC_FRAC23, 0, 0);
		send(FUNC_JUMP, 0, 0);
		send(FUNC_RAW, 0, 0);
		send(FUNC_LONG_JUMP, 0, 0);
		send(FUNC_FRAC52, 0, 0);
		send(FUNC_RANGED, -100, 100);
		send(FUNC_UNUSED, 0, 0);
		// reseed, then a jump right after the reseed, then a raw draw
		send(FUNC_RESEED, 0, 0);
		send(FUNC_JUMP, 0, 0);
		send(FUNC_RAW, 0, 0);

		// random phases, each under its own seed
		for (int p = 0; p < SEED_PHASES; p++) begin
			case (p)
			0:       s = '0;
			1:       s = {$urandom, $urandom};
			2:       s = 64'h1;
			3:       s = 64'h8000_0000_0000_0000;
			4:       s = {$urandom, $urandom};
			default: s = '1;
			endcase
			write_seed(s);
			send(FUNC_RESEED, $urandom, $urandom);
			n = 1;
			while (n < PHASE_ITEMS) begin
				f = pick_func();
				a = pick_bound();
				b = pick_bound();
				// a quarter of ranged draws get a narrow span around a
				if (f == FUNC_RANGED && $urandom_range(0, 3) == 0)
					b = a + int'($urandom_range(0, 20)) - 10;
				send(f, a, b);
				if (f != FUNC_UNUSED) begin
					n++;
					// sender holds off mid-phase until the output side has caught up
					if (n == PHASE_ITEMS / 2) wait_drained();
				end
			end
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		sb.finish_check();

		$display("covered %0d reseeds, %0d jumps, %0d long jumps, %0d unused codes",
		         sb.func_count[FUNC_RESEED], sb.func_count[FUNC_JUMP],
		         sb.func_count[FUNC_LONG_JUMP], sb.func_count[FUNC_UNUSED]);
		$display("checked %0d draws over %0d seed writes, %0d mismatches",
		         sb.checked, sb.seed_writes, sb.errors);
		if (sb.errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ----- xoshiro256plus_generator.f -----
rtl/xoshiro_pkg.sv
rtl/xoshiro_dp.sv
rtl/xoshiro_ctrl.sv
rtl/xoshiro256plus_generator.sv
verif/tb.sv
